// File: design/lte_pkg.sv
// shared types and constants of the letter trie engine
`default_nettype none

package lte_pkg;

    typedef enum logic [3:0] {
        MODE_ALLOC       = 4'd0,
        MODE_BEGIN       = 4'd1,
        MODE_INSERT      = 4'd2,
        MODE_LOOKUP      = 4'd3,
        MODE_QUERY       = 4'd4,
        MODE_MARK        = 4'd5,
        MODE_CLEAR_MARKS = 4'd6,
        MODE_SPELL       = 4'd7,
        MODE_FREE_ALL    = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_BAD_NODE = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_DEPTH    = 3'd3,
        STATUS_STOPPED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SPELL
    } state_t;

    localparam int LETTERS     = 26;
    localparam int MAX_RESULTS = 16;
    localparam int LETTER_W    = 5;
    localparam int POS_W       = 4;

    localparam logic [7:0] CHAR_A  = 8'h61;
    localparam logic [7:0] CHAR_Z  = 8'h7a;
    localparam logic [7:0] CHAR_Q  = 8'h71;
    localparam logic [7:0] CHAR_U  = 8'h75;
    localparam logic [7:0] CHAR_NL = 8'h0a;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [LETTER_W-1:0] Q_INDEX   = 5'd16;
    localparam logic [LETTER_W-1:0] LAST_SLOT = 5'd25;

endpackage

`default_nettype wire

// File: design/lte_ram.sv
// single port pair ram, one write and one registered read per cycle
`default_nettype none

module lte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/letter_trie_engine.sv
// top level of the letter trie engine: command sequencer over node and child memories
//
// channel   signals                                   handshake
// request   start, mode, node, letter                 taken when start && !busy
// result    done, result_node, is_word, marked,       one cycle per result, no stall
//           spelled_letter, position, empty_string,
//           last, status
//
// each request: memory read issued in ST_IDLE, then update in ST_EXEC, where most modes register their result
// a node allocation passes through ST_CLEAR first to zero the child slots of the new node
// clear marks walks the allocated nodes, through ST_MARK_RD and ST_MARK_WR for each
// spell emits one letter per cycle, walking the parent chain in the node memory
// reset clears control state only; entries of unallocated nodes are rewritten
// when the node is handed out, so no clearing pass is needed
// results cannot be held off, busy alone throttles requests
`default_nettype none

module letter_trie_engine #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DEPTH  = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [3:0]                  mode,
    input  wire logic [$clog2(NODE_COUNT)-1:0] node,
    input  wire logic [7:0]                  letter,
    output logic                             done,
    output logic [$clog2(NODE_COUNT)-1:0]    result_node,
    output logic                             is_word,
    output logic                             marked,
    output logic [4:0]                       spelled_letter,
    output logic [3:0]                       position,
    output logic                             empty_string,
    output logic                             last,
    output logic [2:0]                       status
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int UW  = $clog2(NODE_COUNT + 1);
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int CD  = NODE_COUNT * lte_pkg::LETTERS;
    localparam int CAW = $clog2(CD);
    localparam int LW  = lte_pkg::LETTER_W;

    // one node record: parent link, letter, depth, word flag, mark bit
    typedef struct packed {
        logic [NW-1:0] parent;
        logic [LW-1:0] letter;
        logic [DW-1:0] depth;
        logic          word;
        logic          mark;
    } node_entry_t;

    localparam int NMW = $bits(node_entry_t);

    lte_pkg::state_t state_reg, state_next;

    // control state
    logic [UW-1:0]  used_reg, used_next;
    logic [NW-1:0]  cursor_reg, cursor_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic           pending_q_reg, pending_q_next;
    logic           stopped_reg, stopped_next;
    logic           done_reg, done_next;

    // latched request and walk counters
    logic [3:0]     mode_reg, mode_next;
    logic [NW-1:0]  node_reg, node_next;
    logic [7:0]     letter_reg, letter_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic [CAW-1:0] caddr_reg, caddr_next;
    logic [CAW-1:0] clr_addr_reg, clr_addr_next;
    logic [LW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NW-1:0]  sweep_reg, sweep_next;
    logic [DW-1:0]  pos_reg, pos_next;

    // result fields
    logic [NW-1:0]  rnode_reg, rnode_next;
    logic           word_reg, word_next;
    logic           mark_reg, mark_next;
    logic [LW-1:0]  sletter_reg, sletter_next;
    logic [3:0]     position_reg, position_next;
    logic           empty_reg, empty_next;
    logic           last_reg, last_next;
    logic [2:0]     status_reg, status_next;

    // memory ports
    logic           cw_en;
    logic [CAW-1:0] cw_addr;
    logic [NW-1:0]  cw_data;
    logic [CAW-1:0] cr_addr;
    logic [NW-1:0]  cr_data;
    logic           nw_en;
    logic [NW-1:0]  nw_addr;
    node_entry_t    nw_data;
    logic [NW-1:0]  nr_addr;
    node_entry_t    nr_data;

    // request side address generation
    logic [NW-1:0]  req_base;
    logic [LW-1:0]  req_idx;
    logic           req_insert;

    logic           node_ok;
    logic           lower;
    logic           pool_full;
    logic [UW-1:0]  sweep_ext;

    lte_ram #(
        .WIDTH (NW),
        .DEPTH (CD)
    ) u_child_mem (
        .clk     (clk),
        .wr_en   (cw_en),
        .wr_addr (cw_addr),
        .wr_data (cw_data),
        .rd_addr (cr_addr),
        .rd_data (cr_data)
    );

    lte_ram #(
        .WIDTH (NMW),
        .DEPTH (NODE_COUNT)
    ) u_node_mem (
        .clk     (clk),
        .wr_en   (nw_en),
        .wr_addr (nw_addr),
        .wr_data (nw_data),
        .rd_addr (nr_addr),
        .rd_data (nr_data)
    );

    assign req_insert = (mode == lte_pkg::MODE_INSERT);
    assign req_base   = req_insert ? cursor_reg : node;
    assign req_idx    = (req_insert && pending_q_reg) ? lte_pkg::Q_INDEX
                                                      : LW'(letter - lte_pkg::CHAR_A);
    assign cr_addr    = CAW'(req_base) * CAW'(lte_pkg::LETTERS) + CAW'(req_idx);

    assign node_ok   = (node_reg != '0) && (UW'(node_reg) < used_reg);
    assign lower     = (letter_reg >= lte_pkg::CHAR_A) && (letter_reg <= lte_pkg::CHAR_Z);
    assign pool_full = (used_reg >= UW'(NODE_COUNT));
    assign sweep_ext = UW'(sweep_reg) + UW'(1);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cursor_next    = cursor_reg;
        depth_next     = depth_reg;
        pending_q_next = pending_q_reg;
        stopped_next   = stopped_reg;
        done_next      = 1'b0;
        mode_next      = mode_reg;
        node_next      = node_reg;
        letter_next    = letter_reg;
        idx_next       = idx_reg;
        caddr_next     = caddr_reg;
        clr_addr_next  = clr_addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        sweep_next     = sweep_reg;
        pos_next       = pos_reg;
        rnode_next     = rnode_reg;
        word_next      = word_reg;
        mark_next      = mark_reg;
        sletter_next   = sletter_reg;
        position_next  = position_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        cw_en   = 1'b0;
        cw_addr = clr_addr_reg;
        cw_data = '0;
        nw_en   = 1'b0;
        nw_addr = node_reg;
        nw_data = nr_data;
        nr_addr = sweep_reg;

        unique case (state_reg)
            lte_pkg::ST_IDLE:
            begin
                nr_addr = req_base;
                if (start)
                begin
                    mode_next   = mode;
                    node_next   = node;
                    letter_next = letter;
                    idx_next    = req_idx;
                    caddr_next  = cr_addr;
                    state_next  = lte_pkg::ST_EXEC;
                end
            end

            lte_pkg::ST_EXEC:
            begin
                // single result by default, overridden per mode
                nr_addr       = nr_data.parent;
                state_next    = lte_pkg::ST_IDLE;
                done_next     = 1'b1;
                rnode_next    = '0;
                word_next     = 1'b0;
                mark_next     = 1'b0;
                sletter_next  = '0;
                position_next = '0;
                empty_next    = 1'b0;
                last_next     = 1'b1;
                status_next   = lte_pkg::STATUS_OK;

                unique case (mode_reg)
                    lte_pkg::MODE_ALLOC:
                    begin
                        if (pool_full)
                        begin
                            status_next = lte_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            nw_en         = 1'b1;
                            nw_addr       = NW'(used_reg);
                            nw_data       = '0;
                            rnode_next    = NW'(used_reg);
                            used_next     = used_reg + UW'(1);
                            clr_addr_next = CAW'(used_reg) * CAW'(lte_pkg::LETTERS);
                            clr_cnt_next  = '0;
                            done_next     = 1'b0;
                            state_next    = lte_pkg::ST_CLEAR;
                        end
                    end

                    lte_pkg::MODE_BEGIN:
                    begin
                        pending_q_next = 1'b0;
                        if (!node_ok)
                        begin
                            stopped_next = 1'b1;
                            status_next  = lte_pkg::STATUS_BAD_NODE;
                        end
                        else
                        begin
                            cursor_next  = node_reg;
                            depth_next   = nr_data.depth;
                            stopped_next = 1'b0;
                            rnode_next   = node_reg;
                        end
                    end

                    lte_pkg::MODE_INSERT:
                    begin
                        rnode_next = cursor_reg;
                        if (stopped_reg)
                        begin
                            status_next = lte_pkg::STATUS_STOPPED;
                        end
                        else if (pending_q_reg && (letter_reg != lte_pkg::CHAR_U))
                        begin
                            // q not followed by u ends the word
                            pending_q_next = 1'b0;
                            stopped_next   = 1'b1;
                            status_next    = lte_pkg::STATUS_STOPPED;
                        end
                        else if (!pending_q_reg && (letter_reg == lte_pkg::CHAR_Q))
                        begin
                            pending_q_next = 1'b1;
                        end
                        else if (pending_q_reg || lower)
                        begin
                            // descend, creating the child when missing
                            pending_q_next = 1'b0;
                            if (cr_data != '0)
                            begin
                                cursor_next = cr_data;
                                depth_next  = depth_reg + DW'(1);
                                rnode_next  = cr_data;
                            end
                            else if (depth_reg >= DW'(MAX_DEPTH))
                            begin
                                stopped_next = 1'b1;
                                status_next  = lte_pkg::STATUS_DEPTH;
                            end
                            else if (pool_full)
                            begin
                                stopped_next = 1'b1;
                                status_next  = lte_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cw_en          = 1'b1;
                                cw_addr        = caddr_reg;
                                cw_data        = NW'(used_reg);
                                nw_en          = 1'b1;
                                nw_addr        = NW'(used_reg);
                                nw_data.parent = cursor_reg;
                                nw_data.letter = idx_reg;
                                nw_data.depth  = depth_reg + DW'(1);
                                nw_data.word   = 1'b0;
                                nw_data.mark   = 1'b0;
                                cursor_next    = NW'(used_reg);
                                depth_next     = depth_reg + DW'(1);
                                rnode_next     = NW'(used_reg);
                                used_next      = used_reg + UW'(1);
                                clr_addr_next  = CAW'(used_reg) * CAW'(lte_pkg::LETTERS);
                                clr_cnt_next   = '0;
                                done_next      = 1'b0;
                                state_next     = lte_pkg::ST_CLEAR;
                            end
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                            if ((letter_reg == lte_pkg::CHAR_NL) ||
                                (letter_reg == lte_pkg::CHAR_NUL))
                            begin
                                nw_en        = 1'b1;
                                nw_addr      = cursor_reg;
                                nw_data.word = 1'b1;
                            end
                            else
                            begin
                                status_next = lte_pkg::STATUS_STOPPED;
                            end
                        end
                    end

                    lte_pkg::MODE_LOOKUP:
                    begin
                        if (lower)
                        begin
                            if (!node_ok)
                            begin
                                status_next = lte_pkg::STATUS_BAD_NODE;
                            end
                            else
                            begin
                                rnode_next = cr_data;
                            end
                        end
                    end

                    lte_pkg::MODE_QUERY:
                    begin
                        if (!node_ok)
                        begin
                            status_next = lte_pkg::STATUS_BAD_NODE;
                        end
                        else
                        begin
                            rnode_next = node_reg;
                            word_next  = nr_data.word;
                            mark_next  = nr_data.mark;
                        end
                    end

                    lte_pkg::MODE_MARK:
                    begin
                        if (!node_ok)
                        begin
                            status_next = lte_pkg::STATUS_BAD_NODE;
                        end
                        else
                        begin
                            nw_en        = 1'b1;
                            nw_data.mark = 1'b1;
                            rnode_next   = node_reg;
                            mark_next    = 1'b1;
                        end
                    end

                    lte_pkg::MODE_CLEAR_MARKS:
                    begin
                        if (used_reg != UW'(1))
                        begin
                            sweep_next = NW'(1);
                            done_next  = 1'b0;
                            state_next = lte_pkg::ST_MARK_RD;
                        end
                    end

                    lte_pkg::MODE_SPELL:
                    begin
                        if (!node_ok)
                        begin
                            status_next = lte_pkg::STATUS_BAD_NODE;
                        end
                        else
                        begin
                            rnode_next = node_reg;
                            if (nr_data.depth == '0)
                            begin
                                empty_next = 1'b1;
                            end
                            else if (int'(nr_data.depth) > lte_pkg::MAX_RESULTS)
                            begin
                                status_next = lte_pkg::STATUS_DEPTH;
                            end
                            else
                            begin
                                // leaf letter first, parent read issued now
                                sletter_next  = nr_data.letter;
                                position_next = lte_pkg::POS_W'(nr_data.depth - DW'(1));
                                last_next     = (nr_data.depth == DW'(1));
                                if (nr_data.depth != DW'(1))
                                begin
                                    pos_next   = nr_data.depth - DW'(2);
                                    state_next = lte_pkg::ST_SPELL;
                                end
                            end
                        end
                    end

                    lte_pkg::MODE_FREE_ALL:
                    begin
                        used_next      = UW'(1);
                        cursor_next    = '0;
                        depth_next     = '0;
                        pending_q_next = 1'b0;
                        stopped_next   = 1'b1;
                    end

                    default:
                    begin
                        status_next = lte_pkg::STATUS_STOPPED;
                    end
                endcase
            end

            lte_pkg::ST_CLEAR:
            begin
                // zero the child slots of the freshly allocated node
                cw_en         = 1'b1;
                clr_addr_next = clr_addr_reg + CAW'(1);
                clr_cnt_next  = clr_cnt_reg + LW'(1);
                if (clr_cnt_reg == lte_pkg::LAST_SLOT)
                begin
                    done_next  = 1'b1;
                    state_next = lte_pkg::ST_IDLE;
                end
            end

            lte_pkg::ST_MARK_RD:
            begin
                nr_addr    = sweep_reg;
                state_next = lte_pkg::ST_MARK_WR;
            end

            lte_pkg::ST_MARK_WR:
            begin
                nw_en        = 1'b1;
                nw_addr      = sweep_reg;
                nw_data.mark = 1'b0;
                sweep_next   = NW'(sweep_ext);
                if (sweep_ext == used_reg)
                begin
                    done_next  = 1'b1;
                    state_next = lte_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lte_pkg::ST_MARK_RD;
                end
            end

            lte_pkg::ST_SPELL:
            begin
                nr_addr       = nr_data.parent;
                done_next     = 1'b1;
                sletter_next  = nr_data.letter;
                position_next = lte_pkg::POS_W'(pos_reg);
                last_next     = (pos_reg == '0);
                pos_next      = pos_reg - DW'(1);
                if (pos_reg == '0)
                begin
                    state_next = lte_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lte_pkg::ST_IDLE;
            used_reg      <= UW'(1);
            cursor_reg    <= '0;
            depth_reg     <= '0;
            pending_q_reg <= 1'b0;
            stopped_reg   <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cursor_reg    <= cursor_next;
            depth_reg     <= depth_next;
            pending_q_reg <= pending_q_next;
            stopped_reg   <= stopped_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        node_reg     <= node_next;
        letter_reg   <= letter_next;
        idx_reg      <= idx_next;
        caddr_reg    <= caddr_next;
        clr_addr_reg <= clr_addr_next;
        clr_cnt_reg  <= clr_cnt_next;
        sweep_reg    <= sweep_next;
        pos_reg      <= pos_next;
        rnode_reg    <= rnode_next;
        word_reg     <= word_next;
        mark_reg     <= mark_next;
        sletter_reg  <= sletter_next;
        position_reg <= position_next;
        empty_reg    <= empty_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

    assign busy           = (state_reg != lte_pkg::ST_IDLE);
    assign done           = done_reg;
    assign result_node    = rnode_reg;
    assign is_word        = word_reg;
    assign marked         = mark_reg;
    assign spelled_letter = sletter_reg;
    assign position       = position_reg;
    assign empty_string   = empty_reg;
    assign last           = last_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// File: tb/tb_letter_trie_engine.sv
// self-checking testbench of the letter trie engine with its own trie predictor
`default_nettype none

module tb_letter_trie_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES    = 1024;
    localparam int DEPTH    = 16;
    localparam int WDOG_MAX = 20000;

    // one request as driven on the command ports
    typedef struct {
        logic [3:0] mode;
        logic [9:0] node;
        logic [7:0] letter;
        bit         hold;     // sender waits for all results before this one
    } trie_req_t;

    // one result as seen on the result ports
    typedef struct {
        logic [9:0] result_node;
        logic       is_word;
        logic       marked;
        logic [4:0] spelled_letter;
        logic [3:0] position;
        logic       empty_string;
        logic       last;
        logic [2:0] status;
    } trie_res_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [3:0] mode = '0;
    logic [9:0] node = '0;
    logic [7:0] letter = '0;
    logic       busy;
    logic       done;
    logic [9:0] result_node;
    logic       is_word;
    logic       marked;
    logic [4:0] spelled_letter;
    logic [3:0] position;
    logic       empty_string;
    logic       last;
    logic [2:0] status;

    trie_req_t pending_reqs[$];
    trie_res_t trie_results_due[$];
    int        idle_pct = 0;
    int        errors = 0;
    int        req_count = 0;
    int        res_count = 0;
    int        spell_letters = 0;
    int        full_hits = 0;
    int        depth_hits = 0;
    int        quiet_cycles = 0;

    // predicted trie state
    logic [9:0]  child_of[NODES*lte_pkg::LETTERS];
    logic [9:0]  parent_of[NODES];
    logic [4:0]  letter_of[NODES];
    bit          word_end[NODES];
    bit          mark_of[NODES];
    int          used_nodes;
    logic [9:0]  cur_node;
    int          cur_depth;
    bit          q_waiting;
    bit          word_closed;

    always #1 clk = ~clk;

    letter_trie_engine #(.NODE_COUNT(NODES), .MAX_DEPTH(DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .node(node), .letter(letter),
        .done(done), .result_node(result_node), .is_word(is_word),
        .marked(marked), .spelled_letter(spelled_letter), .position(position),
        .empty_string(empty_string), .last(last), .status(status)
    );

    // wipe the whole predicted trie, as after reset or free all
    task automatic trie_clear();
        for (int i = 0; i < NODES*lte_pkg::LETTERS; i++)
            child_of[i] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            parent_of[i] = '0;
            letter_of[i] = '0;
            word_end[i]  = 1'b0;
            mark_of[i]   = 1'b0;
        end
        used_nodes  = 1;
        cur_node    = '0;
        cur_depth   = 0;
        q_waiting   = 1'b0;
        word_closed = 1'b1;
    endtask

    function automatic bit node_ok(logic [9:0] n);
        return n != 0 && int'(n) < used_nodes;
    endfunction

    // number of letters above a node, following the parent links
    function automatic int string_len(logic [9:0] n);
        int         d;
        logic [9:0] t;
        d = 0;
        t = n;
        while (d <= 64 && parent_of[t] != 0)
        begin
            t = parent_of[t];
            d++;
        end
        return d;
    endfunction

    task automatic expect_one(logic [9:0] rn, logic [2:0] st);
        trie_res_t r;
        r = '{rn, 1'b0, 1'b0, 5'd0, 4'd0, 1'b0, 1'b1, st};
        trie_results_due.push_back(r);
    endtask

    // walk down from the cursor along one letter, making the child if missing
    task automatic trie_descend(int idx);
        int slot;
        slot = int'(cur_node) * lte_pkg::LETTERS + idx;
        if (child_of[slot] == 0)
        begin
            if (cur_depth >= DEPTH)
            begin
                word_closed = 1'b1;
                depth_hits++;
                expect_one(cur_node, lte_pkg::STATUS_DEPTH);
                return;
            end
            if (used_nodes >= NODES)
            begin
                word_closed = 1'b1;
                full_hits++;
                expect_one(cur_node, lte_pkg::STATUS_FULL);
                return;
            end
            child_of[slot]        = 10'(used_nodes);
            parent_of[used_nodes] = cur_node;
            letter_of[used_nodes] = 5'(idx);
            used_nodes++;
        end
        cur_node = child_of[slot];
        cur_depth++;
        expect_one(cur_node, lte_pkg::STATUS_OK);
    endtask

    // update the predicted trie for one accepted request and queue its results
    task automatic trie_apply(trie_req_t rq);
        bit         lower;
        int         len;
        logic [9:0] t;
        trie_res_t  r;
        lower = rq.letter >= lte_pkg::CHAR_A && rq.letter <= lte_pkg::CHAR_Z;
        case (rq.mode)
            lte_pkg::MODE_ALLOC:
                if (used_nodes >= NODES)
                begin
                    full_hits++;
                    expect_one('0, lte_pkg::STATUS_FULL);
                end
                else
                begin
                    expect_one(10'(used_nodes), lte_pkg::STATUS_OK);
                    used_nodes++;
                end
            lte_pkg::MODE_BEGIN:
            begin
                q_waiting = 1'b0;
                if (!node_ok(rq.node))
                begin
                    word_closed = 1'b1;
                    expect_one('0, lte_pkg::STATUS_BAD_NODE);
                end
                else
                begin
                    cur_node    = rq.node;
                    cur_depth   = string_len(rq.node);
                    word_closed = 1'b0;
                    expect_one(cur_node, lte_pkg::STATUS_OK);
                end
            end
            lte_pkg::MODE_INSERT:
                if (word_closed)
                    expect_one(cur_node, lte_pkg::STATUS_STOPPED);
                else if (q_waiting)
                begin
                    q_waiting = 1'b0;
                    if (rq.letter != lte_pkg::CHAR_U)
                    begin
                        word_closed = 1'b1;
                        expect_one(cur_node, lte_pkg::STATUS_STOPPED);
                    end
                    else
                        trie_descend(int'(lte_pkg::Q_INDEX));
                end
                else if (rq.letter == lte_pkg::CHAR_Q)
                begin
                    q_waiting = 1'b1;
                    expect_one(cur_node, lte_pkg::STATUS_OK);
                end
                else if (lower)
                    trie_descend(int'(rq.letter - lte_pkg::CHAR_A));
                else
                begin
                    word_closed = 1'b1;
                    if (rq.letter == lte_pkg::CHAR_NL || rq.letter == lte_pkg::CHAR_NUL)
                    begin
                        word_end[cur_node] = 1'b1;
                        expect_one(cur_node, lte_pkg::STATUS_OK);
                    end
                    else
                        expect_one(cur_node, lte_pkg::STATUS_STOPPED);
                end
            lte_pkg::MODE_LOOKUP:
                if (!lower)
                    expect_one('0, lte_pkg::STATUS_OK);
                else if (!node_ok(rq.node))
                    expect_one('0, lte_pkg::STATUS_BAD_NODE);
                else
                    expect_one(child_of[int'(rq.node)*lte_pkg::LETTERS
                                        + int'(rq.letter - lte_pkg::CHAR_A)],
                               lte_pkg::STATUS_OK);
            lte_pkg::MODE_QUERY:
                if (!node_ok(rq.node))
                    expect_one('0, lte_pkg::STATUS_BAD_NODE);
                else
                begin
                    r = '{rq.node, word_end[rq.node], mark_of[rq.node], 5'd0, 4'd0,
                          1'b0, 1'b1, lte_pkg::STATUS_OK};
                    trie_results_due.push_back(r);
                end
            lte_pkg::MODE_MARK:
                if (!node_ok(rq.node))
                    expect_one('0, lte_pkg::STATUS_BAD_NODE);
                else
                begin
                    mark_of[rq.node] = 1'b1;
                    r = '{rq.node, 1'b0, 1'b1, 5'd0, 4'd0, 1'b0, 1'b1, lte_pkg::STATUS_OK};
                    trie_results_due.push_back(r);
                end
            lte_pkg::MODE_CLEAR_MARKS:
            begin
                for (int i = 0; i < NODES; i++)
                    mark_of[i] = 1'b0;
                expect_one('0, lte_pkg::STATUS_OK);
            end
            lte_pkg::MODE_SPELL:
                if (!node_ok(rq.node))
                    expect_one('0, lte_pkg::STATUS_BAD_NODE);
                else
                begin
                    len = string_len(rq.node);
                    if (len == 0)
                    begin
                        r = '{rq.node, 1'b0, 1'b0, 5'd0, 4'd0, 1'b1, 1'b1,
                              lte_pkg::STATUS_OK};
                        trie_results_due.push_back(r);
                    end
                    else if (len > lte_pkg::MAX_RESULTS)
                        expect_one(rq.node, lte_pkg::STATUS_DEPTH);
                    else
                    begin
                        // leaf letter first, position counts from the root side
                        t = rq.node;
                        for (int k = 0; k < len; k++)
                        begin
                            r = '{rq.node, 1'b0, 1'b0, letter_of[t], 4'(len - 1 - k),
                                  1'b0, k == len - 1, lte_pkg::STATUS_OK};
                            trie_results_due.push_back(r);
                            t = parent_of[t];
                        end
                        spell_letters += len;
                    end
                end
            lte_pkg::MODE_FREE_ALL:
            begin
                trie_clear();
                expect_one('0, lte_pkg::STATUS_OK);
            end
            default:
                expect_one('0, lte_pkg::STATUS_STOPPED);
        endcase
    endtask

    // driver: takes the next request when the port is free, the dice allow and any hold is met
    always @(posedge clk)
    begin
        trie_req_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                trie_apply('{mode, node, letter, 1'b0});
                req_count++;
            end
            if (!start || !busy)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct
                    && !(pending_reqs[0].hold && (trie_results_due.size() > 0
                         || (start && !busy))))
                begin
                    nxt = pending_reqs.pop_front();
                    start  <= 1'b1;
                    mode   <= nxt.mode;
                    node   <= nxt.node;
                    letter <= nxt.letter;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: every strobed result is matched against the oldest prediction
    always @(posedge clk)
    begin
        trie_res_t e;
        if (rst_n && done)
        begin
            res_count++;
            if (trie_results_due.size() == 0)
            begin
                $error("unexpected result: result_node %0d status %0d", result_node, status);
                errors++;
            end
            else
            begin
                e = trie_results_due.pop_front();
                check_field("result_node", e.result_node, result_node);
                check_field("is_word", e.is_word, is_word);
                check_field("marked", e.marked, marked);
                check_field("spelled_letter", e.spelled_letter, spelled_letter);
                check_field("position", e.position, position);
                check_field("empty_string", e.empty_string, empty_string);
                check_field("last", e.last, last);
                check_field("status", e.status, status);
            end
        end
    end

    // watchdog: a clear-marks walk over a full pool is the longest quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || pending_reqs.size() == 0
            && trie_results_due.size() == 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX)
        begin
            $display("watchdog expired with %0d results outstanding",
                     trie_results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_req(lte_pkg::mode_t m, int n, int ch, bit hold = 1'b0);
        trie_req_t rq;
        rq.mode   = m;
        rq.node   = 10'(n);
        rq.letter = 8'(ch);
        rq.hold   = hold;
        pending_reqs.push_back(rq);
    endtask

    task automatic push_raw(logic [3:0] m, int n, int ch);
        trie_req_t rq;
        rq.mode   = m;
        rq.node   = 10'(n);
        rq.letter = 8'(ch);
        rq.hold   = 1'b0;
        pending_reqs.push_back(rq);
    endtask

    // keep the generator just ahead of the driver so node picks see a fresh pool
    task automatic throttle();
        while (pending_reqs.size() > 1)
            @(posedge clk);
    endtask

    function automatic int pick_node();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 0;
        if (r < 10)
            return $urandom_range(NODES - 1);
        return $urandom_range(used_nodes > 1 ? used_nodes - 1 : 1, 1);
    endfunction

    // a word: begin at a node, a few letters with some qu pairs, then an ending
    task automatic push_word();
        int n_letters;
        int ch;
        push_req(lte_pkg::MODE_BEGIN, pick_node(), $urandom_range(255));
        n_letters = $urandom_range(6, 1);
        for (int i = 0; i < n_letters; i++)
        begin
            throttle();
            ch = $urandom_range(lte_pkg::CHAR_Z, lte_pkg::CHAR_A);
            if (ch == lte_pkg::CHAR_Q)
            begin
                push_req(lte_pkg::MODE_INSERT, 0, ch);
                ch = ($urandom_range(9) == 0) ? $urandom_range(255) : lte_pkg::CHAR_U;
            end
            push_req(lte_pkg::MODE_INSERT, $urandom_range(NODES - 1), ch);
        end
        ch = $urandom_range(9);
        push_req(lte_pkg::MODE_INSERT, 0, ch < 5 ? lte_pkg::CHAR_NL
                                         : ch < 8 ? lte_pkg::CHAR_NUL : $urandom_range(255));
    endtask

    task automatic push_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            push_req(lte_pkg::MODE_ALLOC, $urandom_range(NODES - 1), $urandom_range(255));
        else if (r < 20)
            push_req(lte_pkg::MODE_INSERT, 0, $urandom_range(255));
        else if (r < 38)
            push_req(lte_pkg::MODE_LOOKUP, pick_node(),
                     $urandom_range(3) == 0 ? $urandom_range(255)
                                            : $urandom_range(lte_pkg::CHAR_Z,
                                                             lte_pkg::CHAR_A));
        else if (r < 52)
            push_req(lte_pkg::MODE_QUERY, pick_node(), $urandom_range(255));
        else if (r < 64)
            push_req(lte_pkg::MODE_MARK, pick_node(), $urandom_range(255));
        else if (r < 68)
            push_req(lte_pkg::MODE_CLEAR_MARKS, $urandom_range(NODES - 1),
                     $urandom_range(255));
        else if (r < 94)
            push_req(lte_pkg::MODE_SPELL, pick_node(), $urandom_range(255));
        else if (r < 96)
            push_req(lte_pkg::MODE_FREE_ALL, $urandom_range(NODES - 1), $urandom_range(255));
        else
            push_raw(4'($urandom_range(15, 9)), $urandom_range(NODES - 1),
                     $urandom_range(255));
    endtask

    initial
    begin
        int pct[4];
        pct = '{0, 74, 0, 6};
        trie_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: stopped insert, bad begin, qu pair, broken q, word flag, then lookup, mark, query, bad mode
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_A);
        push_req(lte_pkg::MODE_BEGIN, 0, 0);
        push_req(lte_pkg::MODE_ALLOC, 0, 0);
        push_req(lte_pkg::MODE_SPELL, 1, 0);
        push_req(lte_pkg::MODE_BEGIN, 1, 0);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_Q);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_U);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_Q);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_Z);
        push_req(lte_pkg::MODE_BEGIN, 2, 0);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_NL);
        push_req(lte_pkg::MODE_LOOKUP, 1023, 8'hff);
        push_req(lte_pkg::MODE_LOOKUP, 1023, lte_pkg::CHAR_Q);
        push_req(lte_pkg::MODE_LOOKUP, 1, lte_pkg::CHAR_Q);
        push_req(lte_pkg::MODE_MARK, 2, 0);
        push_req(lte_pkg::MODE_QUERY, 2, 0);
        push_req(lte_pkg::MODE_CLEAR_MARKS, 0, 0);
        push_req(lte_pkg::MODE_QUERY, 1023, 0);
        push_raw(4'hf, 1023, 8'hff);
        // a chain deep enough to run past the depth limit, then spelled in full
        push_req(lte_pkg::MODE_BEGIN, 1, 0, 1'b1);
        for (int i = 0; i < DEPTH + 1; i++)
            push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_A + 1 + (i % 15));
        push_req(lte_pkg::MODE_SPELL, DEPTH + 2, 0);
        push_req(lte_pkg::MODE_QUERY, 2, 0);

        // random words and operations through the idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pct[ph];
            for (int i = 0; i < 30; i++)
            begin
                throttle();
                if ($urandom_range(99) < 55)
                    push_word();
                else
                    push_random_op();
            end
            // hold the sender until the trie has answered everything
            push_req(lte_pkg::MODE_QUERY, 1, 0, 1'b1);
        end

        // closing checks at the top of the node range, then free all
        idle_pct = 0;
        push_req(lte_pkg::MODE_MARK, NODES - 1, 0);
        push_req(lte_pkg::MODE_BEGIN, NODES - 1, 0);
        push_req(lte_pkg::MODE_INSERT, 0, lte_pkg::CHAR_A + 1);
        push_req(lte_pkg::MODE_CLEAR_MARKS, 0, 0);
        push_req(lte_pkg::MODE_QUERY, NODES - 1, 0);
        push_req(lte_pkg::MODE_SPELL, NODES - 1, 0);
        push_req(lte_pkg::MODE_FREE_ALL, 0, 0);
        push_req(lte_pkg::MODE_QUERY, 1, 0);

        while (pending_reqs.size() > 0 || trie_results_due.size() > 0 || start)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d requests, %0d results checked", req_count, res_count);
        $display("%0d spelled letters, %0d pool-full and %0d depth-limit cases",
                 spell_letters, full_hits, depth_hits);
        if (errors == 0 && trie_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
design/lte_pkg.sv
design/lte_ram.sv
design/letter_trie_engine.sv
tb/tb_letter_trie_engine.sv
